// ===== rtl/bbp_pkg.sv =====
// ----------------------------------------------------------------------------
// bbp_pkg
// shared types and constants of the bimodal branch predictor
// ----------------------------------------------------------------------------
`default_nettype none

package bbp_pkg;

  // input word: branch_address [31:0], actual_taken [32], zero pad to 40 bits
  localparam int ADDR_W     = 32;
  localparam int IN_DATA_W  = 40;
  // output word: predicted_taken, prediction_correct, total, correct
  localparam int COUNT_W    = 32;
  localparam int OUT_DATA_W = 72;

  // configuration registers
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNTER_BITS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_SIZE_LOG2 = 2'd1;
  localparam logic [CFG_DATA_W-1:0] COUNTER_BITS_RST    = 4'd2;
  localparam logic [CFG_DATA_W-1:0] TABLE_SIZE_LOG2_RST = 4'd11;

  // masked address width covers every table_size_log2 a 4-bit register holds
  localparam int MASK_W = 16;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPDATE
  } state_t;

  typedef struct packed {
    logic clr_step;
    logic accept;
    logic update;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
  } status_t;

endpackage

`default_nettype wire

// ===== rtl/bbp_ram.sv =====
// ----------------------------------------------------------------------------
// bbp_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module bbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bbp_dp.sv =====
// ----------------------------------------------------------------------------
// bbp_dp
// datapath: config registers, counter table, counter update and statistics
// ----------------------------------------------------------------------------
`default_nettype none

module bbp_dp #(
  parameter int TABLE_DEPTH       = 2048,
  parameter int COUNTER_WIDTH_MAX = 8
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_wr_en,
  input  wire logic [bbp_pkg::CFG_IDX_W-1:0]    cfg_addr,
  input  wire logic [bbp_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  wire logic [bbp_pkg::IN_DATA_W-1:0]    in_tdata,
  input  wire bbp_pkg::cmd_t                    cmd,
  output bbp_pkg::status_t                      status,
  output logic      [bbp_pkg::OUT_DATA_W-1:0]   out_tdata
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CW    = COUNTER_WIDTH_MAX;
  localparam int EW    = CW + 1;
  localparam int WW    = $clog2(CW + 1);

  logic [bbp_pkg::CFG_DATA_W-1:0] cnt_bits_r;
  logic [bbp_pkg::CFG_DATA_W-1:0] tbl_log2_r;

  logic [IDX_W-1:0] clr_idx_r;
  logic [IDX_W-1:0] idx_r;
  logic             taken_r;

  logic [bbp_pkg::COUNT_W-1:0] total_r, total_nxt;
  logic [bbp_pkg::COUNT_W-1:0] hits_r, hits_nxt;
  logic                        pred_r, ok_r;

  logic [bbp_pkg::MASK_W-1:0] masked;
  logic [IDX_W-1:0]           rd_idx;
  logic [CW-1:0]              rdata;
  logic [WW-1:0]              eff_w;
  logic [EW-1:0]              maxv, mid, cur, stepped, nxt_cnt;
  logic                       pred, ok;
  logic                       ram_we;
  logic [IDX_W-1:0]           ram_waddr;
  logic [CW-1:0]              ram_wdata;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_bits_r <= bbp_pkg::COUNTER_BITS_RST;
      tbl_log2_r <= bbp_pkg::TABLE_SIZE_LOG2_RST;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        bbp_pkg::CFG_COUNTER_BITS:    cnt_bits_r <= cfg_wdata;
        bbp_pkg::CFG_TABLE_SIZE_LOG2: tbl_log2_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // table index: masked address, modulo the table depth
  always_comb begin
    masked = in_tdata[bbp_pkg::MASK_W-1:0] & ~({bbp_pkg::MASK_W{1'b1}} << tbl_log2_r);
    rd_idx = IDX_W'(masked);
  end

  // clearing sweep
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r <= '0;
    end else if (cmd.clr_step) begin
      clr_idx_r <= clr_idx_r + 1'b1;
    end
  end

  assign status.clr_last = (clr_idx_r == IDX_W'(TABLE_DEPTH - 1));

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      idx_r   <= rd_idx;
      taken_r <= in_tdata[bbp_pkg::ADDR_W];
    end
  end

  // counter update
  always_comb begin
    if (cnt_bits_r == '0) begin
      eff_w = WW'(1);
    end else if (5'(cnt_bits_r) > 5'(CW)) begin
      eff_w = WW'(CW);
    end else begin
      eff_w = WW'(cnt_bits_r);
    end
    maxv = (EW'(1) << eff_w) - EW'(1);
    mid  = EW'(1) << (eff_w - WW'(1));
    cur  = EW'(rdata);
    pred = (cur < mid);
    ok   = (pred == taken_r);
    if (taken_r) begin
      stepped = (cur == '0) ? '0 : cur - EW'(1);
    end else begin
      stepped = cur + EW'(1);
    end
    nxt_cnt   = (stepped > maxv) ? maxv : stepped;
    total_nxt = (total_r == '1) ? total_r : total_r + 1'b1;
    hits_nxt  = (ok && hits_r != '1) ? hits_r + 1'b1 : hits_r;
  end

  always_comb begin
    ram_we    = cmd.clr_step | cmd.update;
    ram_waddr = cmd.clr_step ? clr_idx_r : idx_r;
    ram_wdata = cmd.clr_step ? '0 : CW'(nxt_cnt);
  end

  bbp_ram #(
    .WIDTH (CW),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.accept),
    .raddr (rd_idx),
    .rdata (rdata)
  );

  // statistics
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
      hits_r  <= '0;
    end else if (cmd.update) begin
      total_r <= total_nxt;
      hits_r  <= hits_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      pred_r <= pred;
      ok_r   <= ok;
    end
  end

  assign out_tdata = {6'd0, hits_r, total_r, ok_r, pred_r};

endmodule

`default_nettype wire

// ===== rtl/bbp_ctrl.sv =====
// ----------------------------------------------------------------------------
// bbp_ctrl
// controller: clearing sweep, accept, update and output handshake
// ----------------------------------------------------------------------------
`default_nettype none

module bbp_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  input  wire bbp_pkg::status_t  status,
  output bbp_pkg::cmd_t          cmd
);

  bbp_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bbp_pkg::ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_tready     = 1'b0;
    out_valid_nxt = out_valid_r & ~out_tready;
    case (state_r)
      bbp_pkg::ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (status.clr_last) begin
          state_nxt = bbp_pkg::ST_IDLE;
        end
      end
      bbp_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          state_nxt  = bbp_pkg::ST_UPDATE;
        end
      end
      bbp_pkg::ST_UPDATE: begin
        if (!out_valid_r || out_tready) begin
          cmd.update    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = bbp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = bbp_pkg::ST_CLEAR;
      end
    endcase
  end

  assign out_tvalid = out_valid_r;

endmodule

`default_nettype wire

// ===== rtl/bimodal_branch_predictor.sv =====
// ----------------------------------------------------------------------------
// bimodal_branch_predictor
// bimodal predictor with a table of saturating counters and hit statistics
//
//   channel  direction  word contents (lsb first)
//   in_      slave      branch_address[31:0], actual_taken
//   out_     master     predicted_taken, prediction_correct, total, correct
//   cfg_     write      0 counter_bits, 1 table_size_log2
//
// each branch: table read on accept, write-back and result in the update state
// after reset the table is swept to zero, one entry a cycle, with in_tready
// low throughout; config writes are taken during the sweep
// a result waiting in the output register lets the next branch be read,
// its update waits until the output register is free
// ----------------------------------------------------------------------------
`default_nettype none

module bimodal_branch_predictor #(
  parameter int TABLE_DEPTH       = 2048,
  parameter int COUNTER_WIDTH_MAX = 8
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_wr_en,
  input  wire logic [bbp_pkg::CFG_IDX_W-1:0]      cfg_addr,
  input  wire logic [bbp_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // branch_address, actual_taken, zero pad
  input  wire logic [bbp_pkg::IN_DATA_W-1:0]      in_tdata,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // predicted_taken, prediction_correct, total_predictions,
  // correct_predictions, zero pad
  output logic      [bbp_pkg::OUT_DATA_W-1:0]     out_tdata
);

  bbp_pkg::cmd_t    cmd;
  bbp_pkg::status_t status;

  bbp_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  bbp_dp #(
    .TABLE_DEPTH       (TABLE_DEPTH),
    .COUNTER_WIDTH_MAX (COUNTER_WIDTH_MAX)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tdata  (in_tdata),
    .cmd       (cmd),
    .status    (status),
    .out_tdata (out_tdata)
  );

endmodule

`default_nettype wire
